[hw/rtl/positional_list_store_defines.svh]
// Assertion macros shared by the checker of the positional list store.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pls_pkg.sv]
// Package of the positional list store: field widths, command and status
// codes, sequencer states and the control bundle broadcast to the cells.
package pls_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int CNT_W = 5;
  localparam int ST_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_POS  = 3'd0,
    CMD_INS_SORT = 3'd1,
    CMD_DEL_POS  = 3'd2,
    CMD_DEL_VAL  = 3'd3,
    CMD_READ     = 3'd4
  } pls_cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_MISSING = 3'd4
  } pls_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } pls_state_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic eval;   // capture compare flags
    logic ins;    // open a slot at or above the hit cell
    logic del;    // close the gap at or above the hit cell
  } pls_cell_ctl_t;

endpackage

[hw/rtl/pls_if.sv]
// Valid/ready channel interfaces of the positional list store.
// Depends on pls_pkg for the field widths.
interface pls_in_if import pls_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface pls_out_if import pls_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] where;
  logic [VAL_W-1:0] read_value;

  modport source (output valid, output status, output count, output where,
                  output read_value, input ready);
  modport sink   (input valid, input status, input count, input where,
                  input read_value, output ready);
endinterface

[hw/rtl/positional_list_store.sv]
// channel  | dir | handshake    | payload
// in_chan  | in  | valid/ready  | command, position, value
// out_chan | out | valid/ready  | status, count, where, read_value
//
// Each command goes through capture, cell compare, then the ripple of the
// hit marker along the cell row with the shift and the result write.
// One command is in flight at a time; a new one is taken only when idle.
// A result that is not taken holds the block in its last step.
// Synchronous active-low reset clears the count, the sequencer and the result valid.
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pls_in_if.sink     in_chan,
  pls_out_if.source  out_chan
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  pls_state_t       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    count_r, count_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [CNT_W-1:0] out_count_r;
  logic [POS_W-1:0] out_where_r;
  logic [VAL_W-1:0] out_rv_r;

  logic [VAL_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0] le, eq, in_range, pos_ge, seen, after, ge, hit;

  pls_cell_ctl_t ctl;
  logic          accept, apply;
  logic          sel_sorted, sel_delval;
  logic          do_ins, do_del, report, take_rv;
  pls_status_t   status;
  logic [IW-1:0]    k_idx;
  logic [VAL_W-1:0] k_val;

  assign accept     = in_chan.valid & in_chan.ready;
  assign sel_sorted = (cmd_r == CMD_INS_SORT);
  assign sel_delval = (cmd_r == CMD_DEL_VAL);

  // Row of cells with the hit marker rippling through neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;

    assign in_range[g] = (XW'(g) < XW'(count_r));
    assign pos_ge[g]   = (XW'(g) >= XW'(pos_r));

    if (g == 0) begin : g_first
      assign seen[g]  = eq[g];
      assign hit[g]   = ge[g];
      assign left_v   = entry[g];
    end else begin : g_mid
      assign seen[g]  = eq[g] | seen[g-1];
      assign hit[g]   = ge[g] & ~ge[g-1];
      assign left_v   = entry[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign after[g] = ~le[g];
      assign right_v  = entry[g];
    end else begin : g_inner
      assign after[g] = ~le[g] & after[g+1];
      assign right_v  = entry[g+1];
    end

    assign ge[g] = sel_sorted ? after[g] : (sel_delval ? seen[g] : pos_ge[g]);

    pls_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .in_range (in_range[g]),
      .value    (val_r),
      .left     (left_v),
      .right    (right_v),
      .ge       (ge[g]),
      .hit      (hit[g]),
      .entry    (entry[g]),
      .le       (le[g]),
      .eq       (eq[g])
    );
  end

  // Encode the hit cell and pick up its entry
  always_comb begin
    k_idx = '0;
    k_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        k_idx = k_idx | IW'(i);
        k_val = k_val | entry[i];
      end
    end
  end

  // Decide status and the row operation
  always_comb begin
    status  = ST_OK;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    report  = 1'b0;
    take_rv = 1'b0;
    case (cmd_r)
      CMD_INS_POS: begin
        if (count_r == CAP_C) status = ST_FULL;
        else if (XW'(pos_r) > XW'(count_r)) status = ST_BADPOS;
        else begin
          do_ins = 1'b1;
          report = 1'b1;
        end
      end
      CMD_INS_SORT: begin
        if (count_r == CAP_C) status = ST_FULL;
        else begin
          do_ins = 1'b1;
          report = 1'b1;
        end
      end
      CMD_DEL_POS: begin
        if (count_r == '0) status = ST_EMPTY;
        else if (XW'(pos_r) >= XW'(count_r)) status = ST_BADPOS;
        else begin
          do_del  = 1'b1;
          report  = 1'b1;
          take_rv = 1'b1;
        end
      end
      CMD_DEL_VAL: begin
        if (count_r == '0) status = ST_EMPTY;
        else if (!seen[CAPACITY-1]) status = ST_MISSING;
        else begin
          do_del  = 1'b1;
          report  = 1'b1;
          take_rv = 1'b1;
        end
      end
      CMD_READ: begin
        if (count_r == '0) status = ST_EMPTY;
        else if (XW'(pos_r) >= XW'(count_r)) status = ST_BADPOS;
        else begin
          report  = 1'b1;
          take_rv = 1'b1;
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + CW'(1);
    else if (do_del) count_nxt = count_r - CW'(1);
  end

  // Sequencer: capture, compare, apply
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    apply          = 1'b0;
    ctl            = '0;
    case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.eval  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (!out_valid_r || out_chan.ready) begin
          apply     = 1'b1;
          ctl.ins   = do_ins;
          ctl.del   = do_del;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the command for the duration of its work
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_chan.command;
      pos_r <= in_chan.position;
      val_r <= in_chan.value;
    end
  end

  // Advance the entry count
  always_ff @(posedge clk) begin
    if (!rst_n)     count_r <= '0;
    else if (apply) count_r <= count_nxt;
  end

  // Output register: fill on apply, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (apply)          out_valid_r <= 1'b1;
    else if (out_chan.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_status_r <= status;
      out_count_r  <= CNT_W'(count_nxt);
      out_where_r  <= report ? POS_W'(k_idx) : '0;
      out_rv_r     <= take_rv ? k_val : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.count      = out_count_r;
  assign out_chan.where      = out_where_r;
  assign out_chan.read_value = out_rv_r;

endmodule

[hw/rtl/pls_cell.sv]
// One cell of the list row: holds one entry, compares it with the command
// value and shifts from its left or right neighbor. Depends on pls_pkg.
module pls_cell import pls_pkg::*; (
  input  logic             clk,
  input  pls_cell_ctl_t    ctl,
  input  logic             in_range,
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] right,
  input  logic             ge,
  input  logic             hit,
  output logic [VAL_W-1:0] entry,
  output logic             le,
  output logic             eq
);

  logic [VAL_W-1:0] entry_r;
  logic             le_r;
  logic             eq_r;

  // Capture local compare flags; cells past the count never match
  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      le_r <= in_range & ($signed(entry_r) <= $signed(value));
      eq_r <= in_range & (entry_r == value);
    end
  end

  // Load the new value, take the left neighbor on insert, the right on delete
  always_ff @(posedge clk) begin
    if (ctl.ins && ge) begin
      entry_r <= hit ? value : left;
    end else if (ctl.del && ge) begin
      entry_r <= right;
    end
  end

  assign entry = entry_r;
  assign le    = le_r;
  assign eq    = eq_r;

endmodule

[hw/rtl/pls_checker.sv]
// Port-level checker of the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store_defines.svh.
`include "positional_list_store_defines.svh"

module pls_checker import pls_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  out_status,
  input logic [CNT_W-1:0] out_count,
  input logic [POS_W-1:0] out_where,
  input logic [VAL_W-1:0] out_read_value
);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // A stalled result holds its payload
  `PLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_count) && $stable(out_where) && $stable(out_read_value), "result changed while stalled")

  // One command at a time: no transfer in right after a transfer in
  `PLS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  // A failed command reports no index and no value
  `PLS_ASSERT_NOW(a_fail_clean, out_valid && out_status != ST_OK, out_where == '0 && out_read_value == '0, "failed command carries data")

  // Full and empty statuses agree with the reported count
  `PLS_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, out_count == CAP_C, "full with count below capacity")
  `PLS_ASSERT_NOW(a_empty_count, out_valid && out_status == ST_EMPTY, out_count == '0, "empty with nonzero count")

endmodule

bind positional_list_store pls_checker #(.CAPACITY(CAPACITY)) u_pls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_count      (out_chan.count),
  .out_where      (out_chan.where),
  .out_read_value (out_chan.read_value)
);

[sim/tb_positional_list_store.sv]
// Self-checking bench for positional_list_store: directed and random list commands
// are checked against a list model kept in the bench.
// Depends on pls_pkg and the pls_in_if / pls_out_if channel interfaces.
module tb_positional_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int CAPACITY     = 16;
  localparam int LONG_HOLD    = 90;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 50;
  localparam int PRINT_LIMIT  = 40;

  typedef enum int {FILL_UP, CHURN, DRAIN_DOWN} phase_kind_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] where;
    logic [VAL_W-1:0] read_value;
  } outcome_t;

  // List model plus the queue of outcomes still owed by the block.
  class list_tracker;
    logic [VAL_W-1:0] held [CAPACITY];
    int unsigned      held_count;
    outcome_t         awaited_outcomes [$];
    int unsigned      mismatch_count;
    int unsigned      command_count;
    int unsigned      peak_count;
    int unsigned      unknown_tally;
    int unsigned      status_tally [int'(ST_MISSING) + 1];

    function new();
      held_count     = 0;
      mismatch_count = 0;
      command_count  = 0;
      peak_count     = 0;
      unknown_tally  = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Shift later entries up and drop the value into the freed slot.
    function void open_slot(int unsigned at, logic [VAL_W-1:0] v);
      for (int unsigned i = held_count; i > at; i--) held[i] = held[i - 1];
      held[at] = v;
      held_count++;
    endfunction

    // Shift later entries down over the removed one.
    function logic [VAL_W-1:0] close_slot(int unsigned at);
      logic [VAL_W-1:0] gone;
      gone = held[at];
      for (int unsigned i = at; i + 1 < held_count; i++) held[i] = held[i + 1];
      held_count--;
      return gone;
    endfunction

    // Apply one accepted command to the model and queue its outcome.
    function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VAL_W-1:0] val);
      outcome_t    o;
      int unsigned slot;
      bit          known;
      o.status     = ST_OK;
      o.where      = '0;
      o.read_value = '0;
      known        = 1'b1;
      case (cmd)
        CMD_INS_POS: begin
          if (held_count >= CAPACITY) o.status = ST_FULL;
          else if (pos > held_count) o.status = ST_BADPOS;
          else begin
            open_slot(pos, val);
            o.where = pos;
          end
        end
        CMD_INS_SORT: begin
          if (held_count >= CAPACITY) o.status = ST_FULL;
          else begin
            // land after any equal entries
            slot = held_count;
            while (slot > 0 && $signed(held[slot - 1]) > $signed(val)) slot--;
            open_slot(slot, val);
            o.where = POS_W'(slot);
          end
        end
        CMD_DEL_POS: begin
          if (held_count == 0) o.status = ST_EMPTY;
          else if (pos >= held_count) o.status = ST_BADPOS;
          else begin
            o.read_value = close_slot(pos);
            o.where      = pos;
          end
        end
        CMD_DEL_VAL: begin
          if (held_count == 0) o.status = ST_EMPTY;
          else begin
            slot = 0;
            while (slot < held_count && held[slot] != val) slot++;
            if (slot == held_count) o.status = ST_MISSING;
            else begin
              o.read_value = close_slot(slot);
              o.where      = POS_W'(slot);
            end
          end
        end
        CMD_READ: begin
          if (held_count == 0) o.status = ST_EMPTY;
          else if (pos >= held_count) o.status = ST_BADPOS;
          else begin
            o.read_value = held[pos];
            o.where      = pos;
          end
        end
        default: known = 1'b0;
      endcase
      o.count = CNT_W'(held_count);
      command_count++;
      if (known) status_tally[o.status]++;
      else unknown_tally++;
      if (held_count > peak_count) peak_count = held_count;
      awaited_outcomes.push_back(o);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one transferred result with the oldest owed outcome.
    task check_outcome(logic [ST_W-1:0] status, logic [CNT_W-1:0] count,
                       logic [POS_W-1:0] where, logic [VAL_W-1:0] read_value);
      outcome_t e;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d count %0d",
                                  status, count));
        return;
      end
      e = awaited_outcomes.pop_front();
      if (status !== e.status)
        report_mismatch($sformatf("status got %0d want %0d", status, e.status));
      if (count !== e.count)
        report_mismatch($sformatf("count got %0d want %0d", count, e.count));
      if (where !== e.where)
        report_mismatch($sformatf("where got %0d want %0d", where, e.where));
      if (read_value !== e.read_value)
        report_mismatch($sformatf("read_value got %0d want %0d",
                                  $signed(read_value), $signed(e.read_value)));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  bit          hold_request = 1'b0;
  bit          steady_send  = 1'b0;
  bit          steady_recv  = 1'b0;
  int unsigned idle_cycles  = 0;

  list_tracker tracker = new();

  pls_in_if  in_chan ();
  pls_out_if out_chan ();

  positional_list_store #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Small values for duplicates, the extremes, or any word.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return VAL_W'(int'($urandom_range(0, 8)) - 4);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return VAL_W'($urandom);
  endfunction

  // Offer one command after a random gap and hold it until the transfer.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = pick_gap(steady_send);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.command  <= cmd;
    in_chan.position <= pos;
    in_chan.value    <= val;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    tracker.note_command(cmd, pos, val);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic await_all_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_outcomes.size() != 0);
  endtask

  // Stimulus: reset, directed corner cases, then biased random phases.
  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    phase_kind_t      kind;
    int unsigned      r;
    int unsigned      top;
    int unsigned      c0, c1, c2, c3, c4;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.command  = '0;
    in_chan.position = '0;
    in_chan.value    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty list and bad insert positions
    send_command(CMD_READ, 0, 0);
    send_command(CMD_DEL_POS, 0, 0);
    send_command(CMD_DEL_VAL, 0, 0);
    send_command(CMD_INS_POS, 1, 7);
    send_command(CMD_INS_POS, 31, 7);
    // build a short list from the extremes, with a sorted duplicate
    send_command(CMD_INS_POS, 0, 32'h7FFF_FFFF);
    send_command(CMD_INS_SORT, 31, 32'h8000_0000);
    send_command(CMD_INS_SORT, 0, 5);
    send_command(CMD_INS_SORT, 0, 5);
    send_command(CMD_INS_POS, 4, 32'hFFFF_FFFF);
    // reads and deletes at and past the end
    send_command(CMD_READ, 4, 0);
    send_command(CMD_READ, 5, 0);
    send_command(CMD_READ, 31, 0);
    send_command(CMD_DEL_POS, 5, 0);
    send_command(CMD_DEL_VAL, 0, 12345);
    send_command(CMD_DEL_VAL, 0, 5);
    // unknown commands leave the list alone
    for (int k = 1; k <= 3; k++)
      send_command(CMD_W'(int'(CMD_READ) + k), 31, 32'hFFFF_FFFF);
    send_command(CMD_DEL_POS, 0, 0);
    send_command(CMD_INS_POS, 2, 0);
    send_command(CMD_DEL_VAL, 0, 32'hFFFF_FFFF);
    send_command(CMD_READ, 0, 0);

    // random phases cycling through filling, churning and draining
    for (int phase = 0; phase < PHASES; phase++) begin
      kind        = phase_kind_t'(phase % 3);
      steady_send = (phase == 2 || phase == 7);
      steady_recv = (phase == 4 || phase == 7);
      // long receiver hold while the sender keeps offering
      if (phase == 2) hold_request = 1'b1;
      // sender pause until the block is fully drained
      if (phase == 5) await_all_results();
      case (kind)
        FILL_UP: begin c0 = 40; c1 = 75; c2 = 83; c3 = 90; c4 = 97; end
        CHURN:   begin c0 = 20; c1 = 40; c2 = 60; c3 = 78; c4 = 96; end
        default: begin c0 = 7;  c1 = 14; c2 = 52; c3 = 82; c4 = 97; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < c0) cmd = CMD_INS_POS;
        else if (r < c1) cmd = CMD_INS_SORT;
        else if (r < c2) cmd = CMD_DEL_POS;
        else if (r < c3) cmd = CMD_DEL_VAL;
        else if (r < c4) cmd = CMD_READ;
        else cmd = CMD_W'(int'(CMD_READ) + $urandom_range(1, 3));
        // mostly in range, sometimes anywhere in the field
        if (cmd == CMD_INS_POS || cmd == CMD_INS_SORT) top = tracker.held_count;
        else top = (tracker.held_count > 0) ? tracker.held_count - 1 : 0;
        if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, top));
        else pos = POS_W'($urandom_range(0, 31));
        // value deletes mostly target a held entry
        if (cmd == CMD_DEL_VAL && tracker.held_count > 0 && $urandom_range(0, 99) < 70)
          val = tracker.held[$urandom_range(0, tracker.held_count - 1)];
        else val = pick_value();
        send_command(cmd, pos, val);
      end
    end

    await_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d commands: %0d ok, %0d full, %0d empty, %0d bad position,",
             tracker.command_count, tracker.status_tally[ST_OK], tracker.status_tally[ST_FULL],
             tracker.status_tally[ST_EMPTY], tracker.status_tally[ST_BADPOS]);
    $display("  %0d not found, %0d unknown; list peaked at %0d of %0d, %0d mismatches.",
             tracker.status_tally[ST_MISSING], tracker.unknown_tally, tracker.peak_count,
             CAPACITY, tracker.mismatch_count);
    if (tracker.mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random ready gaps, steady stretches and the long hold.
  initial begin : result_sink
    int unsigned gap;
    out_chan.ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap(steady_recv);
        if (gap > 0) begin
          out_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Check every result transfer and end the run if traffic stops.
  always @(posedge clk) begin : result_check
    if (rst_n === 1'b1) begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        tracker.check_outcome(out_chan.status, out_chan.count, out_chan.where,
                              out_chan.read_value);
        idle_cycles = 0;
      end else if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                 IDLE_LIMIT, tracker.awaited_outcomes.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pls_pkg.sv
hw/rtl/pls_if.sv
hw/rtl/pls_cell.sv
hw/rtl/positional_list_store.sv
hw/rtl/pls_checker.sv
sim/tb_positional_list_store.sv
